/* design/assert_macros.svh */
// Assertion macros used by the parser core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent holds.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/ptpsp_pkg.sv */
// Types and constants of the PTP sync message parser.
`default_nettype none

package ptpsp_pkg;

   localparam logic [15:0] HEADER_BYTES   = 16'd34;
   localparam logic [15:0] SYNC_END_BYTES = 16'd44;
   localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
   localparam logic [3:0]  PTP_VERSION    = 4'd2;
   localparam logic [3:0]  SYNC_TYPE      = 4'd0;
   localparam logic [29:0] NANOS_PER_SEC  = 30'd1_000_000_000;

   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_SHORT_HEADER = 3'd1,
      STATUS_BAD_VERSION  = 3'd2,
      STATUS_SHORT_DATA   = 3'd3,
      STATUS_NOT_SYNC     = 3'd4,
      STATUS_SHORT_SYNC   = 3'd5,
      STATUS_BAD_NANOS    = 3'd6
   } status_type;

   // One accepted byte handed to the capture stage.
   typedef struct packed {
      logic       advance;
      logic       last;
      logic [7:0] data;
   } step_type;

   // Per-packet capture state; seconds are kept already scaled to nanoseconds.
   typedef struct packed {
      logic [15:0] byte_count;
      logic [3:0]  transport;
      logic [3:0]  msg_type;
      logic [3:0]  version;
      logic [15:0] declared_length;
      logic [7:0]  domain;
      logic [15:0] flags;
      logic [63:0] correction;
      logic [63:0] clock_id;
      logic [15:0] port;
      logic [15:0] seq_num;
      logic [7:0]  control;
      logic [7:0]  interval;
      logic [63:0] sec_scaled;
      logic [31:0] nanos;
   } capture_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  transport_field;
      logic [3:0]  msg_kind;
      logic [7:0]  domain_id;
      logic [15:0] flag_bits;
      logic [63:0] correction_value;
      logic [63:0] source_clock_id;
      logic [15:0] source_port;
      logic [15:0] sequence_number;
      logic [7:0]  control_byte;
      logic [7:0]  log_interval;
      logic [63:0] timestamp_ns;
   } result_type;

endpackage

`default_nettype wire

/* design/ptpsp_channels.sv */
// Valid/ready channel interfaces for packet bytes and parse results.
`default_nettype none

interface ptpsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, data_byte, last_byte, input ready);
   modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface ptpsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [3:0]  transport_field;
   logic [3:0]  msg_kind;
   logic [7:0]  domain_id;
   logic [15:0] flag_bits;
   logic [63:0] correction_value;
   logic [63:0] source_clock_id;
   logic [15:0] source_port;
   logic [15:0] sequence_number;
   logic [7:0]  control_byte;
   logic [7:0]  log_interval;
   logic [63:0] timestamp_ns;

   modport source (output valid, status, transport_field, msg_kind, domain_id,
                   flag_bits, correction_value, source_clock_id, source_port,
                   sequence_number, control_byte, log_interval, timestamp_ns,
                   input ready);
   modport sink (input valid, status, transport_field, msg_kind, domain_id,
                 flag_bits, correction_value, source_clock_id, source_port,
                 sequence_number, control_byte, log_interval, timestamp_ns,
                 output ready);
endinterface

`default_nettype wire

/* design/ptpsp_capture.sv */
// Header and sync body field capture at fixed byte offsets.
`default_nettype none

module ptpsp_capture (
   input  wire                    clock,
   input  wire                    reset,
   input  wire ptpsp_pkg::step_type step,
   output ptpsp_pkg::capture_type snap
);
   import ptpsp_pkg::*;

   capture_type state_ff;
   logic [15:0] pos;
   logic [37:0] sec_term;

   assign pos      = state_ff.byte_count;
   assign sec_term = 38'(step.data) * 38'(NANOS_PER_SEC);

   // snap is the state with the current byte folded in
   always_comb begin
      snap = state_ff;
      snap.byte_count = (state_ff.byte_count == COUNT_MAX) ? COUNT_MAX
                                                           : state_ff.byte_count + 16'd1;
      if (pos == 16'd0) begin
         snap.transport = step.data[7:4];
         snap.msg_type  = step.data[3:0];
      end else if (pos == 16'd1) begin
         snap.version = step.data[3:0];
      end else if (pos <= 16'd3) begin
         snap.declared_length = {state_ff.declared_length[7:0], step.data};
      end else if (pos == 16'd4) begin
         snap.domain = step.data;
      end else if (pos == 16'd6 || pos == 16'd7) begin
         snap.flags = {state_ff.flags[7:0], step.data};
      end else if (pos >= 16'd8 && pos <= 16'd15) begin
         snap.correction = {state_ff.correction[55:0], step.data};
      end else if (pos >= 16'd20 && pos <= 16'd27) begin
         snap.clock_id = {state_ff.clock_id[55:0], step.data};
      end else if (pos == 16'd28 || pos == 16'd29) begin
         snap.port = {state_ff.port[7:0], step.data};
      end else if (pos == 16'd30 || pos == 16'd31) begin
         snap.seq_num = {state_ff.seq_num[7:0], step.data};
      end else if (pos == 16'd32) begin
         snap.control = step.data;
      end else if (pos == 16'd33) begin
         snap.interval = step.data;
      end else if (pos >= 16'd34 && pos <= 16'd39) begin
         // seconds * 1e9 built a byte at a time, modulo 2^64
         snap.sec_scaled = {state_ff.sec_scaled[55:0], 8'h00} + 64'(sec_term);
      end else if (pos >= 16'd40 && pos <= 16'd43) begin
         snap.nanos = {state_ff.nanos[23:0], step.data};
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step.advance && step.last)) begin
         state_ff <= '0;
      end else if (step.advance) begin
         state_ff <= snap;
      end
   end

endmodule

`default_nettype wire

/* design/ptpsp_result.sv */
// Status checks, field masking and the result output register.
`default_nettype none

module ptpsp_result (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         load,
   input  wire ptpsp_pkg::capture_type snap,
   ptpsp_rsp_if.source                 rsp_chan
);
   import ptpsp_pkg::*;

   result_type result_in;
   result_type result_ff;
   logic       valid_ff;
   logic       valid_in;
   status_type status;
   logic       nanos_bad;

   assign nanos_bad = snap.nanos >= 32'(NANOS_PER_SEC);

   always_comb begin
      if (snap.byte_count < HEADER_BYTES) begin
         status = STATUS_SHORT_HEADER;
      end else if (snap.version != PTP_VERSION) begin
         status = STATUS_BAD_VERSION;
      end else if (snap.byte_count < snap.declared_length) begin
         status = STATUS_SHORT_DATA;
      end else if (snap.msg_type != SYNC_TYPE) begin
         status = STATUS_NOT_SYNC;
      end else if (snap.byte_count < SYNC_END_BYTES) begin
         status = STATUS_SHORT_SYNC;
      end else if (nanos_bad) begin
         status = STATUS_BAD_NANOS;
      end else begin
         status = STATUS_OK;
      end
   end

   always_comb begin
      result_in = '0;
      result_in.status = status;
      if (status != STATUS_SHORT_HEADER) begin
         result_in.transport_field = snap.transport;
         result_in.msg_kind        = snap.msg_type;
      end
      case (status)
         STATUS_OK, STATUS_NOT_SYNC, STATUS_SHORT_SYNC, STATUS_BAD_NANOS: begin
            result_in.domain_id        = snap.domain;
            result_in.flag_bits        = snap.flags;
            result_in.correction_value = snap.correction;
            result_in.source_clock_id  = snap.clock_id;
            result_in.source_port      = snap.port;
            result_in.sequence_number  = snap.seq_num;
            result_in.control_byte     = snap.control;
            result_in.log_interval     = snap.interval;
         end
         default: begin
         end
      endcase
      if (status == STATUS_OK) begin
         result_in.timestamp_ns = snap.sec_scaled + 64'(snap.nanos);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid            = valid_ff;
   assign rsp_chan.status           = result_ff.status;
   assign rsp_chan.transport_field  = result_ff.transport_field;
   assign rsp_chan.msg_kind         = result_ff.msg_kind;
   assign rsp_chan.domain_id        = result_ff.domain_id;
   assign rsp_chan.flag_bits        = result_ff.flag_bits;
   assign rsp_chan.correction_value = result_ff.correction_value;
   assign rsp_chan.source_clock_id  = result_ff.source_clock_id;
   assign rsp_chan.source_port      = result_ff.source_port;
   assign rsp_chan.sequence_number  = result_ff.sequence_number;
   assign rsp_chan.control_byte     = result_ff.control_byte;
   assign rsp_chan.log_interval     = result_ff.log_interval;
   assign rsp_chan.timestamp_ns     = result_ff.timestamp_ns;

endmodule

`default_nettype wire

/* design/ptp_sync_message_parser_core.sv */
// A packet's last byte waits in the input register until the output is free; the result
// register loads as that byte advances.
// Throughput: one byte per cycle while the output is free; back-to-back one-byte packets give one result per cycle.
// Seconds are scaled by 1e9 one byte at a time as they arrive, so the final stage
// folds in the last byte, then one 64-bit add and the status compares.
// Reset is synchronous, active high: it drops both valids and clears packet state.
`default_nettype none

module ptp_sync_message_parser_core (
   input  wire         clock,
   input  wire         reset,
   ptpsp_req_if.sink   req_chan,
   ptpsp_rsp_if.source rsp_chan
);
   import ptpsp_pkg::*;

   logic        in_valid_ff;
   logic        in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        req_take;
   logic        out_free;
   logic        in_adv;
   step_type    step;
   capture_type snap;

   assign out_free = !rsp_chan.valid || rsp_chan.ready;
   // a non-final byte only updates capture state, so it never waits on the output
   assign in_adv   = in_valid_ff && (!in_last_ff || out_free);
   assign req_chan.ready = !in_valid_ff || in_adv;
   assign req_take = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (in_adv) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_byte_ff <= req_chan.data_byte;
         in_last_ff <= req_chan.last_byte;
      end
   end

   assign step.advance = in_adv;
   assign step.last    = in_last_ff;
   assign step.data    = in_byte_ff;

   ptpsp_capture u_capture (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .snap  (snap)
   );

   ptpsp_result u_result (
      .clock    (clock),
      .reset    (reset),
      .load     (in_adv && in_last_ff),
      .snap     (snap),
      .rsp_chan (rsp_chan)
   );

`include "assert_macros.svh"

   `ASSERT_NEXT(a_last_gives_result, clock, reset, in_adv && in_last_ff, rsp_chan.valid, "packet end produced no result")
   `ASSERT_CLK(a_result_from_last, clock, reset, $rose(rsp_chan.valid) |-> $past(in_adv && in_last_ff), "result without a packet end")
   `ASSERT_CLK(a_short_header_zero, clock, reset, (rsp_chan.valid && rsp_chan.status == STATUS_SHORT_HEADER) |-> (rsp_chan.timestamp_ns == 64'd0 && rsp_chan.source_clock_id == 64'd0 && rsp_chan.msg_kind == 4'd0), "short header result carries fields")

endmodule

`default_nettype wire

/* tb/ptp_sync_message_parser_core_tb.sv */
// Testbench for the PTP sync message parser core: packet stimulus, result checking.
`timescale 1ns / 100ps

module ptp_sync_message_parser_core_tb;
   import ptpsp_pkg::*;

   localparam int CYCLE_LIMIT = 200_000;
   localparam int HOLD_CYCLES = 300;
   localparam int TOTAL_BYTES = 800;

   // Expected parse results; tracks the packet being received byte by byte.
   class sync_parse_book;
      result_type  expected_q[$];
      int          errors;
      logic [15:0] count;
      logic [3:0]  transport, msg_type, version;
      logic [15:0] dlen, flags, port, seq_id;
      logic [7:0]  domain, control, interval;
      logic [63:0] correction, clock_id;
      logic [47:0] seconds;
      logic [31:0] nanos;

      function new();
         errors = 0;
         clear_packet();
      endfunction

      function void clear_packet();
         count = '0; transport = '0; msg_type = '0; version = '0;
         dlen = '0; flags = '0; port = '0; seq_id = '0;
         domain = '0; control = '0; interval = '0;
         correction = '0; clock_id = '0; seconds = '0; nanos = '0;
      endfunction

      function void note_byte(logic [7:0] b, logic last);
         result_type r;
         if (count == 0) begin
            transport = b[7:4];
            msg_type  = b[3:0];
         end else if (count == 1) begin
            version = b[3:0];
         end else if (count <= 3) begin
            dlen = {dlen[7:0], b};
         end else if (count == 4) begin
            domain = b;
         end else if (count == 6 || count == 7) begin
            flags = {flags[7:0], b};
         end else if (count >= 8 && count <= 15) begin
            correction = {correction[55:0], b};
         end else if (count >= 20 && count <= 27) begin
            clock_id = {clock_id[55:0], b};
         end else if (count == 28 || count == 29) begin
            port = {port[7:0], b};
         end else if (count == 30 || count == 31) begin
            seq_id = {seq_id[7:0], b};
         end else if (count == 32) begin
            control = b;
         end else if (count == 33) begin
            interval = b;
         end else if (count >= 34 && count <= 39) begin
            seconds = {seconds[39:0], b};
         end else if (count >= 40 && count <= 43) begin
            nanos = {nanos[23:0], b};
         end
         if (count != COUNT_MAX) count++;
         if (!last) return;

         r = '0;
         if (count < HEADER_BYTES) r.status = STATUS_SHORT_HEADER;
         else if (version != PTP_VERSION) r.status = STATUS_BAD_VERSION;
         else if (count < dlen) r.status = STATUS_SHORT_DATA;
         else if (msg_type != SYNC_TYPE) r.status = STATUS_NOT_SYNC;
         else if (count < SYNC_END_BYTES) r.status = STATUS_SHORT_SYNC;
         else if (nanos >= 32'(NANOS_PER_SEC)) r.status = STATUS_BAD_NANOS;
         else r.status = STATUS_OK;

         if (r.status != STATUS_SHORT_HEADER) begin
            r.transport_field = transport;
            r.msg_kind        = msg_type;
         end
         if (r.status == STATUS_OK || r.status >= STATUS_NOT_SYNC) begin
            r.domain_id        = domain;
            r.flag_bits        = flags;
            r.correction_value = correction;
            r.source_clock_id  = clock_id;
            r.source_port      = port;
            r.sequence_number  = seq_id;
            r.control_byte     = control;
            r.log_interval     = interval;
         end
         // product wraps modulo 2^64
         if (r.status == STATUS_OK)
            r.timestamp_ns = 64'(seconds) * 64'(NANOS_PER_SEC) + 64'(nanos);
         expected_q.push_back(r);
         clear_packet();
      endfunction

      function void check_field(string name, logic [63:0] want, logic [63:0] seen);
         if (want !== seen) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
            errors++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            $error("result with status %0d arrived with none expected", got.status);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         check_field("status", want.status, got.status);
         check_field("transport_field", want.transport_field, got.transport_field);
         check_field("msg_kind", want.msg_kind, got.msg_kind);
         check_field("domain_id", want.domain_id, got.domain_id);
         check_field("flag_bits", want.flag_bits, got.flag_bits);
         check_field("correction_value", want.correction_value, got.correction_value);
         check_field("source_clock_id", want.source_clock_id, got.source_clock_id);
         check_field("source_port", want.source_port, got.source_port);
         check_field("sequence_number", want.sequence_number, got.sequence_number);
         check_field("control_byte", want.control_byte, got.control_byte);
         check_field("log_interval", want.log_interval, got.log_interval);
         check_field("timestamp_ns", want.timestamp_ns, got.timestamp_ns);
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   hold_req;
   int   cycles;
   int   burst_left;
   int   bytes_sent;
   logic [7:0] pkt[$];
   sync_parse_book book;

   ptpsp_req_if req_if ();
   ptpsp_rsp_if rsp_if ();

   ptp_sync_message_parser_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("ptp_sync_message_parser_core_tb failed");
      $finish;
   end

   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.status           = status_type'(rsp_if.status);
         got.transport_field  = rsp_if.transport_field;
         got.msg_kind         = rsp_if.msg_kind;
         got.domain_id        = rsp_if.domain_id;
         got.flag_bits        = rsp_if.flag_bits;
         got.correction_value = rsp_if.correction_value;
         got.source_clock_id  = rsp_if.source_clock_id;
         got.source_port      = rsp_if.source_port;
         got.sequence_number  = rsp_if.sequence_number;
         got.control_byte     = rsp_if.control_byte;
         got.log_interval     = rsp_if.log_interval;
         got.timestamp_ns     = rsp_if.timestamp_ns;
         book.check_result(got);
      end
   end

   // Receiver: ready pattern re-picked at random from four modes as it runs; long hold-off on request.
   initial begin : rsp_stall
      int tick;
      int mode;
      tick = 0;
      mode = 0;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_req) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            if (tick % 50 == 0) mode = $urandom_range(0, 3);
            case (mode)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= 1'($urandom_range(0, 1));
               2: rsp_if.ready <= (tick % 4 == 0);
               default: rsp_if.ready <= ($urandom_range(0, 9) != 0);
            endcase
            tick++;
            @(negedge clock);
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the byte is taken.
   task automatic push_byte(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(0, 4) == 0 ? 500 : $urandom_range(1, 30);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      req_if.last_byte <= last;
      do @(posedge clock); while (!req_if.ready);
      book.note_byte(b, last);
      bytes_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic send_packet();
      foreach (pkt[i]) push_byte(pkt[i], i == pkt.size() - 1);
   endtask

   // Sender pause until every expected result has come back.
   task automatic drain();
      req_if.valid <= 1'b0;
      while (book.expected_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic void build_packet(int len, logic [3:0] ver, logic [3:0] mtype,
                                        logic [15:0] dlen, logic [47:0] secs,
                                        logic [31:0] ns);
      pkt.delete();
      for (int i = 0; i < len; i++) pkt.push_back(8'($urandom));
      if (len > 0) pkt[0] = {pkt[0][7:4], mtype};
      if (len > 1) pkt[1] = {pkt[1][7:4], ver};
      if (len > 3) begin
         pkt[2] = dlen[15:8];
         pkt[3] = dlen[7:0];
      end
      for (int i = 0; i < 6; i++)
         if (34 + i < len) pkt[34 + i] = secs[47 - 8 * i -: 8];
      for (int i = 0; i < 4; i++)
         if (40 + i < len) pkt[40 + i] = ns[31 - 8 * i -: 8];
   endfunction

   function automatic void fill_packet(int len, logic [7:0] value);
      pkt.delete();
      for (int i = 0; i < len; i++) pkt.push_back(value);
   endfunction

   function automatic logic [47:0] rand_seconds();
      logic [63:0] wide;
      wide = {$urandom, $urandom};
      return $urandom_range(0, 9) == 0 ? 48'hFFFF_FFFF_FFFF : wide[47:0];
   endfunction

   function automatic logic [31:0] rand_nanos();
      case ($urandom_range(0, 9))
         0: return 32'd999_999_999;
         1: return 32'd0;
         2: return 32'(NANOS_PER_SEC) + $urandom_range(0, 3);
         3: return $urandom;
         default: return $urandom_range(0, 999_999_999);
      endcase
   endfunction

   // Mostly well-formed Sync packets, mixed at random with broken ones and short noise.
   task automatic send_random_packet();
      int kind;
      int len;
      logic [15:0] dlen;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         len = 44 + ($urandom_range(0, 7) == 0 ? $urandom_range(0, 40) : $urandom_range(0, 8));
         case ($urandom_range(0, 9))
            0: dlen = 16'(len + $urandom_range(1, 3));
            1: dlen = 16'(len);
            2: dlen = 16'd0;
            default: dlen = 16'($urandom_range(34, len));
         endcase
         build_packet(len, $urandom_range(0, 19) == 0 ? 4'($urandom) : PTP_VERSION,
                      $urandom_range(0, 9) == 0 ? 4'($urandom) : SYNC_TYPE,
                      dlen, rand_seconds(), rand_nanos());
      end else if (kind < 85) begin
         len = $urandom_range(1, 50);
         build_packet(len, $urandom_range(0, 1) ? PTP_VERSION : 4'($urandom),
                      4'($urandom), 16'($urandom), rand_seconds(), rand_nanos());
      end else begin
         len = $urandom_range(1, 8);
         build_packet(len, 4'($urandom), 4'($urandom), 16'($urandom), '0, '0);
      end
      send_packet();
   endtask

   initial begin
      book = new();
      hold_req = 1'b0;
      burst_left = 0;
      bytes_sent = 0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data_byte = 8'h00;
      req_if.last_byte = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: at least one packet per status code and the field extremes
      build_packet(1, PTP_VERSION, SYNC_TYPE, 16'd0, '0, '0);
      send_packet();
      build_packet(33, PTP_VERSION, SYNC_TYPE, 16'd33, '0, '0);
      send_packet();
      build_packet(34, 4'd3, SYNC_TYPE, 16'd34, '0, '0);
      send_packet();
      build_packet(34, PTP_VERSION, SYNC_TYPE, 16'd35, '0, '0);
      send_packet();
      build_packet(44, PTP_VERSION, 4'hB, 16'd44, rand_seconds(), 32'd5);
      send_packet();
      build_packet(34, PTP_VERSION, SYNC_TYPE, 16'd34, '0, '0);
      send_packet();
      build_packet(43, PTP_VERSION, SYNC_TYPE, 16'd43, 48'h1234_5678_9ABC, 32'd0);
      send_packet();
      build_packet(44, PTP_VERSION, SYNC_TYPE, 16'd44, 48'd1, 32'(NANOS_PER_SEC));
      send_packet();
      build_packet(44, PTP_VERSION, SYNC_TYPE, 16'd40, 48'd7, 32'hFFFF_FFFF);
      send_packet();
      build_packet(44, PTP_VERSION, SYNC_TYPE, 16'd44, 48'hFFFF_FFFF_FFFF, 32'd999_999_999);
      send_packet();
      build_packet(44, PTP_VERSION, SYNC_TYPE, 16'd0, '0, '0);
      send_packet();
      build_packet(60, PTP_VERSION, SYNC_TYPE, 16'd60, rand_seconds(), 32'd1);
      send_packet();
      fill_packet(44, 8'hFF);
      send_packet();
      fill_packet(44, 8'h00);
      send_packet();
      drain();

      // receiver holds off while short packets keep arriving
      hold_req = 1'b1;
      repeat (40) begin
         build_packet($urandom_range(1, 3), 4'($urandom), 4'($urandom), '0, '0, '0);
         send_packet();
      end
      drain();

      while (bytes_sent < TOTAL_BYTES) begin
         send_random_packet();
      end

      req_if.valid <= 1'b0;
      while (book.expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (book.errors == 0) begin
         $display("ptp_sync_message_parser_core_tb passed");
      end else begin
         $display("ptp_sync_message_parser_core_tb failed");
      end
      $finish;
   end

endmodule
